FILE: hw/rtl/grc_pkg.sv
// shared types, constants and sine table function for the grid ray caster
package grc_pkg;

    localparam int S_TDATA_W = 64;
    localparam int M_TDATA_W = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 12;

    localparam int POS_W = 11;
    localparam int RANGE_W = 9;
    localparam int ACC_W = 25;
    localparam int FRAC_BITS = 14;
    localparam int TRUNC_BIAS = (1 << FRAC_BITS) - 1;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_SCAN = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_RANGE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_START_ANGLE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_STEP = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_BEAM_COUNT = 3'd6;

    localparam logic [8:0] RST_GRID_WIDTH = 9'd256;
    localparam logic [8:0] RST_GRID_HEIGHT = 9'd256;
    localparam logic [8:0] RST_MIN_RANGE = 9'd0;
    localparam logic [8:0] RST_MAX_RANGE = 9'd100;
    localparam logic signed [11:0] RST_START_ANGLE = -12'sd736;
    localparam logic [11:0] RST_ANGLE_STEP = 12'd23;
    localparam logic [6:0] RST_BEAM_COUNT = 7'd64;

    localparam logic signed [7:0] OCC_LIMIT = 8'sd10;

    localparam logic [63:0] PI_Q30 = 64'd3373259426;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
    localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;

    localparam logic [63:0] TAYLOR_DIV [1:8] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                                  64'd110, 64'd156, 64'd210, 64'd272};

    typedef logic signed [15:0] q14_t;

    // q30 angle to q1.14 sine, taylor series to x^17
    function automatic q14_t q14_sin(input logic [63:0] theta_in);
        logic [63:0] th;
        logic [63:0] term;
        logic [63:0] sum;
        logic [15:0] mag;
        logic neg;
        th = theta_in;
        neg = 1'b0;
        if (th >= PI_Q30) begin
            neg = 1'b1;
            th = th - PI_Q30;
        end
        if (th > HALF_PI_Q30) begin
            th = PI_Q30 - th;
        end
        term = th;
        sum = th;
        for (int k = 1; k <= 8; k++) begin
            term = (term * th) >> 30;
            term = (term * th) >> 30;
            term = term / TAYLOR_DIV[k];
            if (k[0]) begin
                sum = (sum >= term) ? sum - term : 64'd0;
            end else begin
                sum = sum + term;
            end
        end
        sum = (sum + 64'd32768) >> 16;
        if (sum > 64'd16384) begin
            sum = 64'd16384;
        end
        mag = 16'(sum);
        return neg ? q14_t'(-mag) : q14_t'(mag);
    endfunction

endpackage

FILE: hw/rtl/grc_ram.sv
// generic simple dual-port ram with registered read
module grc_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

FILE: hw/rtl/grc_trig_rom.sv
// sine and cosine lookup rom in q1.14, built at elaboration, registered read
module grc_trig_rom #(
    parameter int ANGLE_UNITS = 4096
) (
    input  logic                           aclk,
    input  logic [$clog2(ANGLE_UNITS)-1:0] addr,
    output grc_pkg::q14_t                  sin_q,
    output grc_pkg::q14_t                  cos_q
);

    import grc_pkg::*;

    q14_t sin_tab [ANGLE_UNITS];
    q14_t cos_tab [ANGLE_UNITS];

    for (genvar a = 0; a < ANGLE_UNITS; a++) begin : g_tab
        localparam logic [63:0] TH = (64'(a) * TWO_PI_Q30 + 64'(ANGLE_UNITS / 2))
                                     / 64'(ANGLE_UNITS);
        localparam logic [63:0] TC_RAW = TH + HALF_PI_Q30;
        localparam logic [63:0] TC = (TC_RAW >= TWO_PI_Q30) ? TC_RAW - TWO_PI_Q30 : TC_RAW;
        assign sin_tab[a] = q14_sin(TH);
        assign cos_tab[a] = q14_sin(TC);
    end

    always_ff @(posedge aclk) begin
        sin_q <= sin_tab[addr];
        cos_q <= cos_tab[addr];
    end

endmodule

FILE: hw/rtl/grid_ray_cast_scan_core.sv
// occupancy grid ray caster: grid store, beam sequencer and ray step pipeline
//
//  channel  dir  ports                             contents
//  s_       in   s_tvalid s_tready s_tdata s_tuser  grid write or scan pose
//  m_       out  m_tvalid m_tready m_tdata m_tlast  one range per beam
//  cfg_     in   cfg_wr_en cfg_index cfg_wdata      seven scan registers
//
//  a write transaction leaves the block ready; a scan first wraps the bearing and step into range,
//  then per beam probes n cells (at most max_range - min_range + 1) in the ray step pipeline,
//  one cell per cycle, bounded by the single read port of the grid ram
//  synchronous aresetn clears control and config registers; the grid is undefined until written
//  a beam result waits in its state while the output register is full
module grid_ray_cast_scan_core #(
    parameter int GRID_SIDE = 256,
    parameter int MAX_BEAMS = 64,
    parameter int ANGLE_UNITS = 4096
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // cell_addr, cell_value, pos_x, pos_y, heading, zero pad
    input  logic [grc_pkg::S_TDATA_W-1:0]      s_tdata,
    // cmd
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // beam_index, range_cells, zero pad
    output logic [grc_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                               m_tlast,
    input  logic                               cfg_wr_en,
    input  logic [grc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [grc_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    import grc_pkg::*;

    localparam int GRID_CELLS = GRID_SIDE * GRID_SIDE;
    localparam int XW = $clog2(GRID_SIDE);
    localparam int AW = $clog2(GRID_CELLS);
    localparam int AGW = $clog2(ANGLE_UNITS);
    localparam int BW = ((AGW > 12) ? AGW : 12) + 2;
    localparam int KW = $clog2(MAX_BEAMS + 1);
    localparam logic signed [BW-1:0] N_S = BW'(ANGLE_UNITS);
    localparam logic [BW-1:0] N_U = BW'(ANGLE_UNITS);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_NORM = 3'd1;
    localparam logic [2:0] S_TRIG = 3'd2;
    localparam logic [2:0] S_MULX = 3'd3;
    localparam logic [2:0] S_MULY = 3'd4;
    localparam logic [2:0] S_RUN = 3'd5;
    localparam logic [2:0] S_EMIT = 3'd6;

    // configuration
    logic [8:0]         grid_width_reg;
    logic [8:0]         grid_height_reg;
    logic [8:0]         min_range_reg;
    logic [8:0]         max_range_reg;
    logic signed [11:0] start_angle_reg;
    logic [11:0]        angle_step_reg;
    logic [6:0]         beam_count_reg;

    // input fields
    logic        in_cmd;
    logic [15:0] in_cell_addr;
    logic [7:0]  in_cell_value;
    logic signed [POS_W-1:0] in_pos_x;
    logic signed [POS_W-1:0] in_pos_y;
    logic [11:0] in_heading;
    logic        in_accept;

    // sequencer
    logic [2:0]              state_reg;
    logic [KW-1:0]           beam_reg;
    logic [KW-1:0]           nb_reg;
    logic signed [BW-1:0]    ang_reg;
    logic [BW-1:0]           stp_reg;
    logic signed [POS_W-1:0] px_reg;
    logic signed [POS_W-1:0] py_reg;
    q14_t                    c_reg;
    q14_t                    s_reg;
    logic [RANGE_W-1:0]      range_reg;

    // ray step pipeline
    logic                       a_v_reg;
    logic [RANGE_W-1:0]         j_reg;
    logic signed [ACC_W-1:0]    acc_x_reg;
    logic signed [ACC_W-1:0]    acc_y_reg;
    logic                       b_v_reg;
    logic [RANGE_W-1:0]         b_j_reg;
    logic signed [POS_W:0]      x_b_reg;
    logic signed [POS_W:0]      y_b_reg;
    logic                       c_v_reg;
    logic [RANGE_W-1:0]         c_j_reg;
    logic                       c_oob_reg;
    logic [AW-1:0]              c_addr_reg;
    logic                       d_v_reg;
    logic [RANGE_W-1:0]         d_j_reg;
    logic                       d_oob_reg;

    // output register
    logic               m_tvalid_reg;
    logic [5:0]         m_beam_reg;
    logic [RANGE_W-1:0] m_range_reg;
    logic               m_last_reg;

    logic [8:0]               w_eff;
    logic [8:0]               h_eff;
    logic [KW-1:0]            nb_cfg;
    logic signed [BW-1:0]     ang_fix;
    logic [BW-1:0]            stp_fix;
    logic                     ang_ok;
    logic                     stp_ok;
    logic signed [BW-1:0]     ang_sum;
    logic signed [BW-1:0]     ang_wrap;
    q14_t                     sin_q;
    q14_t                     cos_q;
    q14_t                     mul_b;
    logic signed [ACC_W-1:0]  mul_p;
    logic signed [POS_W:0]    x_calc;
    logic signed [POS_W:0]    y_calc;
    logic                     oob_calc;
    logic [AW-1:0]            addr_calc;
    logic [7:0]               rd_data;
    logic                     ram_we;
    logic                     occupied;
    logic                     done;
    logic                     out_free;
    logic                     load_out;
    logic                     out_last;

    function automatic logic signed [POS_W:0] ray_coord(
        input logic signed [POS_W-1:0] base,
        input logic signed [ACC_W-1:0] acc
    );
        logic signed [ACC_W-1:0] biased;
        biased = acc + (acc[ACC_W-1] ? ACC_W'(TRUNC_BIAS) : ACC_W'(0));
        return (POS_W + 1)'(base) + (POS_W + 1)'(biased >>> FRAC_BITS);
    endfunction

    assign in_cmd        = s_tuser;
    assign in_cell_addr  = s_tdata[15:0];
    assign in_cell_value = s_tdata[23:16];
    assign in_pos_x      = s_tdata[34:24];
    assign in_pos_y      = s_tdata[45:35];
    assign in_heading    = s_tdata[57:46];

    assign s_tready  = (state_reg == S_IDLE);
    assign in_accept = s_tvalid && s_tready;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_width_reg  <= RST_GRID_WIDTH;
            grid_height_reg <= RST_GRID_HEIGHT;
            min_range_reg   <= RST_MIN_RANGE;
            max_range_reg   <= RST_MAX_RANGE;
            start_angle_reg <= RST_START_ANGLE;
            angle_step_reg  <= RST_ANGLE_STEP;
            beam_count_reg  <= RST_BEAM_COUNT;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_GRID_WIDTH:  grid_width_reg  <= cfg_wdata[8:0];
                REG_GRID_HEIGHT: grid_height_reg <= cfg_wdata[8:0];
                REG_MIN_RANGE:   min_range_reg   <= cfg_wdata[8:0];
                REG_MAX_RANGE:   max_range_reg   <= cfg_wdata[8:0];
                REG_START_ANGLE: start_angle_reg <= cfg_wdata;
                REG_ANGLE_STEP:  angle_step_reg  <= cfg_wdata;
                REG_BEAM_COUNT:  beam_count_reg  <= cfg_wdata[6:0];
                default: begin
                end
            endcase
        end
    end

    assign w_eff  = ({2'b00, grid_width_reg} > 11'(GRID_SIDE)) ? 9'(GRID_SIDE) : grid_width_reg;
    assign h_eff  = ({2'b00, grid_height_reg} > 11'(GRID_SIDE)) ? 9'(GRID_SIDE)
                                                                 : grid_height_reg;
    assign nb_cfg = (beam_count_reg > 7'(MAX_BEAMS)) ? KW'(MAX_BEAMS) : KW'(beam_count_reg);

    // bearing wrap
    always_comb begin
        ang_ok = (ang_reg >= 0) && (ang_reg < N_S);
        stp_ok = (stp_reg < N_U);
        if (ang_reg < 0) begin
            ang_fix = ang_reg + N_S;
        end else if (ang_reg >= N_S) begin
            ang_fix = ang_reg - N_S;
        end else begin
            ang_fix = ang_reg;
        end
        stp_fix  = stp_ok ? stp_reg : stp_reg - N_U;
        ang_sum  = ang_reg + $signed(stp_reg);
        ang_wrap = (ang_sum >= N_S) ? ang_sum - N_S : ang_sum;
    end

    grc_trig_rom #(
        .ANGLE_UNITS(ANGLE_UNITS)
    ) u_trig_rom (
        .aclk  (aclk),
        .addr  (ang_reg[AGW-1:0]),
        .sin_q (sin_q),
        .cos_q (cos_q)
    );

    // shared setup multiplier: first step offset
    assign mul_b = (state_reg == S_MULX) ? cos_q : s_reg;
    assign mul_p = ACC_W'($signed({1'b0, min_range_reg})) * ACC_W'(mul_b);

    assign x_calc = ray_coord(px_reg, acc_x_reg);
    assign y_calc = ray_coord(py_reg, acc_y_reg);

    assign oob_calc = (x_b_reg < 0) || (y_b_reg < 0)
                   || (x_b_reg >= $signed((POS_W + 1)'(w_eff)))
                   || (y_b_reg >= $signed((POS_W + 1)'(h_eff)));
    assign addr_calc = AW'(x_b_reg[XW-1:0]) + AW'(y_b_reg[XW-1:0]) * AW'(w_eff);

    assign ram_we = in_accept && (in_cmd == CMD_WRITE) && (32'(in_cell_addr) < 32'(GRID_CELLS));

    grc_ram #(
        .DATA_W(8),
        .DEPTH (GRID_CELLS)
    ) u_grid_ram (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (AW'(in_cell_addr)),
        .wr_data (in_cell_value),
        .rd_addr (c_addr_reg),
        .rd_data (rd_data)
    );

    assign occupied = ($signed(rd_data) >= OCC_LIMIT);
    assign done     = d_v_reg && (d_oob_reg || occupied || (d_j_reg == max_range_reg));
    assign out_free = !m_tvalid_reg || m_tready;
    assign load_out = (state_reg == S_EMIT) && out_free;
    assign out_last = (({1'b0, beam_reg} + 1'b1) == {1'b0, nb_reg});

    // sequencer and pipeline control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            beam_reg     <= '0;
            nb_reg       <= '0;
            a_v_reg      <= 1'b0;
            b_v_reg      <= 1'b0;
            c_v_reg      <= 1'b0;
            d_v_reg      <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (in_accept && (in_cmd == CMD_SCAN)) begin
                        beam_reg  <= '0;
                        nb_reg    <= nb_cfg;
                        state_reg <= S_NORM;
                    end
                end
                S_NORM: begin
                    if (ang_ok && stp_ok) begin
                        state_reg <= (nb_reg == '0) ? S_IDLE : S_TRIG;
                    end
                end
                S_TRIG: begin
                    state_reg <= S_MULX;
                end
                S_MULX: begin
                    state_reg <= S_MULY;
                end
                S_MULY: begin
                    if (min_range_reg > max_range_reg) begin
                        state_reg <= S_EMIT;
                    end else begin
                        a_v_reg   <= 1'b1;
                        state_reg <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (done) begin
                        a_v_reg   <= 1'b0;
                        b_v_reg   <= 1'b0;
                        c_v_reg   <= 1'b0;
                        d_v_reg   <= 1'b0;
                        state_reg <= S_EMIT;
                    end else begin
                        if (a_v_reg && (j_reg == max_range_reg)) begin
                            a_v_reg <= 1'b0;
                        end
                        b_v_reg <= a_v_reg;
                        c_v_reg <= b_v_reg;
                        d_v_reg <= c_v_reg;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        if (out_last) begin
                            state_reg <= S_IDLE;
                        end else begin
                            beam_reg  <= beam_reg + 1'b1;
                            state_reg <= S_TRIG;
                        end
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (in_accept && (in_cmd == CMD_SCAN)) begin
            ang_reg <= BW'(in_heading) + BW'(start_angle_reg);
            stp_reg <= BW'(angle_step_reg);
            px_reg  <= in_pos_x;
            py_reg  <= in_pos_y;
        end
        if (state_reg == S_NORM) begin
            ang_reg <= ang_fix;
            stp_reg <= stp_fix;
        end
        if (load_out) begin
            ang_reg <= ang_wrap;
        end
        if (state_reg == S_MULX) begin
            c_reg     <= cos_q;
            s_reg     <= sin_q;
            acc_x_reg <= mul_p;
        end
        if (state_reg == S_MULY) begin
            acc_y_reg <= mul_p;
            j_reg     <= min_range_reg;
            range_reg <= max_range_reg;
        end
        if ((state_reg == S_RUN) && a_v_reg && (j_reg != max_range_reg)) begin
            j_reg     <= j_reg + 1'b1;
            acc_x_reg <= acc_x_reg + ACC_W'(c_reg);
            acc_y_reg <= acc_y_reg + ACC_W'(s_reg);
        end
        if ((state_reg == S_RUN) && done) begin
            range_reg <= d_j_reg;
        end
        b_j_reg    <= j_reg;
        x_b_reg    <= x_calc;
        y_b_reg    <= y_calc;
        c_j_reg    <= b_j_reg;
        c_oob_reg  <= oob_calc;
        c_addr_reg <= addr_calc;
        d_j_reg    <= c_j_reg;
        d_oob_reg  <= c_oob_reg;
        if (load_out) begin
            m_beam_reg  <= 6'(beam_reg);
            m_range_reg <= range_reg;
            m_last_reg  <= out_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, m_range_reg, m_beam_reg};
    assign m_tlast  = m_last_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_RUN) |-> !(a_v_reg || b_v_reg || c_v_reg || d_v_reg))
        else $error("ray step pipeline active outside run state");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && (s_tuser == CMD_SCAN)) |=> !s_tready)
        else $error("scan transaction did not make the block busy");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_TRIG) |-> ((ang_reg >= 0) && (ang_reg < N_S)))
        else $error("bearing out of table range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg != S_IDLE) && (state_reg != S_NORM)) |-> (beam_reg < nb_reg))
        else $error("beam counter past beam count");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (load_out && out_last) |=> (state_reg == S_IDLE))
        else $error("scan did not end after last beam");

endmodule
